// ===== hdl/gmc_pkg.sv =====
// Shared types and constants of the multi-column time-series compressor.
package gmc_pkg;

    // Default number of value columns the block can track.
    localparam int MAX_COLUMNS_DEF = 16;

    // Field widths of items and registers.
    localparam int REQ_W      = 2;
    localparam int TS_W       = 64;
    localparam int VAL_W      = 64;
    localparam int COL_W      = 4;
    localparam int CHUNK_W    = 64;
    localparam int LEN_W      = 7;
    localparam int NCOL_W     = 5;
    localparam int FDW_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Depth of the queue between the classifier and the encoder.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELTA_WIDTH = 2'd1;

    // Request kinds on the input stream.
    localparam logic [REQ_W-1:0] REQ_OPEN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ROW   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_VALUE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd3;

    // Encoding operations handed from the classifier to the encoder.
    typedef enum logic [2:0] {
        OP_HEADER,
        OP_FIRST_TIME,
        OP_TIME,
        OP_FIRST_VALUE,
        OP_VALUE,
        OP_CLOSE
    } t_op_code;

    // One queued operation. For timestamps data holds the delta, for the
    // header the start time, for values the raw value bits.
    typedef struct packed {
        t_op_code          op;
        logic [TS_W-1:0]   data;
        logic [COL_W-1:0]  col;
    } t_op;

endpackage

// ===== hdl/gmc_front.sv =====
// Front end: accepts items, keeps the row timing state and classifies items.
module gmc_front #(
    parameter int MAX_COLUMNS = gmc_pkg::MAX_COLUMNS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gmc_pkg::REQ_W-1:0]     i_req_type,
    input  logic [gmc_pkg::TS_W-1:0]      i_timestamp,
    input  logic [gmc_pkg::VAL_W-1:0]     i_value_bits,
    input  logic [gmc_pkg::COL_W-1:0]     i_column,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output gmc_pkg::t_op                  o_q_item,
    output logic [gmc_pkg::FDW_W-1:0]     o_fdw
);

    // Wide enough for the column register and for MAX_COLUMNS itself.
    localparam int CW = $clog2(MAX_COLUMNS + 32);
    localparam logic [gmc_pkg::FDW_W-1:0] FDW_MAX = 6'd32;

    logic [gmc_pkg::NCOL_W-1:0] r_num_columns;
    logic [gmc_pkg::FDW_W-1:0]  r_fdw;
    logic [gmc_pkg::TS_W-1:0]   r_block_start;
    logic [gmc_pkg::TS_W-1:0]   r_prev_time;
    logic                       r_first_row_pending;
    logic                       r_in_first_row;

    logic                       accept;
    logic                       push;
    logic                       col_ok;
    logic [CW-1:0]              ncol_cfg;
    logic [CW-1:0]              ncol_eff;
    logic [gmc_pkg::TS_W-1:0]   base;
    logic [gmc_pkg::TS_W-1:0]   delta;
    gmc_pkg::t_op               item;

    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    assign ncol_cfg = CW'(r_num_columns);
    assign ncol_eff = (ncol_cfg == '0) ? CW'(1) :
                      (ncol_cfg > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : ncol_cfg;
    assign col_ok   = CW'(i_column) < ncol_eff;

    assign o_fdw = (r_fdw == '0) ? 6'd1 : (r_fdw > FDW_MAX) ? FDW_MAX : r_fdw;

    // The first row measures from the block start, later rows from the last row.
    assign base  = r_first_row_pending ? r_block_start : r_prev_time;
    assign delta = i_timestamp - base;

    always_comb begin
        push      = 1'b1;
        item.op   = gmc_pkg::OP_CLOSE;
        item.data = i_timestamp;
        item.col  = i_column;
        unique case (i_req_type)
            gmc_pkg::REQ_OPEN: begin
                item.op = gmc_pkg::OP_HEADER;
            end
            gmc_pkg::REQ_ROW: begin
                item.op   = r_first_row_pending ? gmc_pkg::OP_FIRST_TIME : gmc_pkg::OP_TIME;
                item.data = delta;
            end
            gmc_pkg::REQ_VALUE: begin
                item.op   = r_in_first_row ? gmc_pkg::OP_FIRST_VALUE : gmc_pkg::OP_VALUE;
                item.data = i_value_bits;
                push      = col_ok && !r_first_row_pending;
            end
            default: begin
                item.op = gmc_pkg::OP_CLOSE;
            end
        endcase
    end

    assign o_q_push = accept && push;
    assign o_q_item = item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_columns       <= 5'd1;
            r_fdw               <= 6'd14;
            r_block_start       <= '0;
            r_prev_time         <= '0;
            r_first_row_pending <= 1'b1;
            r_in_first_row      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gmc_pkg::CFG_NUM_COLUMNS:       r_num_columns <= i_cfg_data[gmc_pkg::NCOL_W-1:0];
                    gmc_pkg::CFG_FIRST_DELTA_WIDTH: r_fdw         <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                unique case (i_req_type)
                    gmc_pkg::REQ_OPEN: begin
                        r_block_start       <= i_timestamp;
                        r_prev_time         <= '0;
                        r_first_row_pending <= 1'b1;
                        r_in_first_row      <= 1'b0;
                    end
                    gmc_pkg::REQ_ROW: begin
                        r_prev_time         <= i_timestamp;
                        r_first_row_pending <= 1'b0;
                        r_in_first_row      <= r_first_row_pending;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== hdl/gmc_fifo.sv =====
// Short queue of classified operations between the front end and the encoder.
module gmc_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  gmc_pkg::t_op i_item,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output gmc_pkg::t_op o_head
);

    localparam int PTR_W = (gmc_pkg::QUEUE_DEPTH > 1) ? $clog2(gmc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(gmc_pkg::QUEUE_DEPTH + 1);

    gmc_pkg::t_op     r_mem [gmc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(gmc_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(gmc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(gmc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

// ===== hdl/gmc_back.sv =====
// Encoder: XOR and zero counting stage, chunk forming stage and output register.
module gmc_back #(
    parameter int MAX_COLUMNS = gmc_pkg::MAX_COLUMNS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  gmc_pkg::t_op                i_q_head,
    output logic                        o_q_pop,
    input  logic [gmc_pkg::FDW_W-1:0]   i_fdw,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gmc_pkg::CHUNK_W-1:0] o_bits,
    output logic [gmc_pkg::LEN_W-1:0]   o_len,
    output logic                        o_last
);

    localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    localparam logic [63:0] PFX_7    = 64'h02 << 7;
    localparam logic [63:0] PFX_9    = 64'h06 << 9;
    localparam logic [63:0] PFX_12   = 64'h0E << 12;
    localparam logic [63:0] PFX_32   = 64'h0F << 32;
    localparam logic [63:0] TRAILER  = (64'h0F << 33) | (64'hFFFF_FFFF << 1);
    localparam logic [63:0] CTRL_NEW = 64'h3 << 11;
    localparam logic [63:0] CTRL_OLD = 64'h2;
    localparam logic [4:0]  LEAD_CAP = 5'd31;

    function automatic logic [3:0] lzc8(input logic [7:0] b);
        logic [3:0] n;
        logic       done;
        n    = 4'd0;
        done = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!done && !b[i]) n = n + 4'd1;
            else done = 1'b1;
        end
        return n;
    endfunction

    // Leading zeros of a 64-bit word as eight byte counts and a group pick.
    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [6:0] n;
        logic       done;
        logic [3:0] g;
        n    = 7'd0;
        done = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            g = lzc8(x[k*8 +: 8]);
            if (!done) begin
                n = n + {3'd0, g};
                if (g != 4'd8) done = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [6:0] tzc64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[i] = x[63 - i];
        return lzc64(r);
    endfunction

    // Stores: previous values and per-column windows.
    logic [63:0]            r_prev_mem [MAX_COLUMNS];
    logic [4:0]             r_wl_mem [MAX_COLUMNS];
    logic [5:0]             r_wt_mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] r_wv;

    // Evaluate stage.
    logic                   r_e_valid;
    gmc_pkg::t_op           r_e;
    logic [63:0]            r_e_prev;
    logic [63:0]            r_prev_delta;

    // Chunk stage.
    logic                   r_c_valid;
    gmc_pkg::t_op_code      r_c_op;
    logic [63:0]            r_c_data;
    logic                   r_c_zero;
    logic [6:0]             r_c_lz;
    logic [6:0]             r_c_tz;
    logic [IDX_W-1:0]       r_c_idx;
    logic                   r_c_second;
    logic [4:0]             r_wl_rd;
    logic [5:0]             r_wt_rd;
    logic [63:0]            r_pay;
    logic [6:0]             r_pay_len;

    // Output register.
    logic                   r_o_valid;
    logic [63:0]            r_o_bits;
    logic [6:0]             r_o_len;
    logic                   r_o_last;

    logic [IDX_W-1:0]       q_idx;
    logic [IDX_W-1:0]       e_idx;
    logic                   e_move;
    logic [63:0]            dod;
    logic [31:0]            zz_low;
    logic [63:0]            x;
    logic [63:0]            n_c_data;
    logic                   n_c_zero;

    logic                   o_free;
    logic                   two;
    logic                   c_emit;
    logic                   c_done;
    logic                   c_take;
    logic [4:0]             lzc;
    logic                   eq;
    logic [5:0]             tz_adj;
    logic [63:0]            x_adj;
    logic                   reuse;
    logic [5:0]             shamt;
    logic [6:0]             sig;
    logic [63:0]            payload;
    logic [31:0]            low;
    logic [63:0]            f_bits;
    logic [6:0]             f_len;

    assign q_idx   = IDX_W'(i_q_head.col);
    assign e_idx   = IDX_W'(r_e.col);
    assign e_move  = r_e_valid && c_take;
    assign o_q_pop = !i_q_empty && (!r_e_valid || e_move);

    // Evaluate: delta-of-delta with zigzag, or XOR with zero counts.
    assign dod    = r_e.data - r_prev_delta;
    assign zz_low = {dod[30:0], 1'b0} ^ {32{dod[63]}};
    assign x      = r_e_prev ^ r_e.data;

    always_comb begin
        case (r_e.op)
            gmc_pkg::OP_TIME:  n_c_data = {32'd0, zz_low};
            gmc_pkg::OP_VALUE: n_c_data = x;
            default:           n_c_data = r_e.data;
        endcase
        n_c_zero = (r_e.op == gmc_pkg::OP_TIME) ? (dod == '0) : (x == '0);
    end

    // The previous value is read as an operation enters evaluate and is replaced
    // at the same edge, so the next value of the same column sees the new one.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_e      <= i_q_head;
            r_e_prev <= r_prev_mem[q_idx];
            if (i_q_head.op == gmc_pkg::OP_VALUE || i_q_head.op == gmc_pkg::OP_FIRST_VALUE) begin
                r_prev_mem[q_idx] <= i_q_head.data;
            end
        end
        if (e_move) begin
            r_c_op   <= r_e.op;
            r_c_data <= n_c_data;
            r_c_zero <= n_c_zero;
            r_c_lz   <= lzc64(x);
            r_c_tz   <= tzc64(x);
            r_c_idx  <= e_idx;
            r_wl_rd  <= r_wl_mem[e_idx];
            r_wt_rd  <= r_wt_mem[e_idx];
        end
    end

    // Chunk forming for a changed value.
    assign lzc     = (r_c_lz > 7'd31) ? LEAD_CAP : r_c_lz[4:0];
    assign eq      = {2'd0, lzc} == r_c_tz;
    assign tz_adj  = eq ? 6'd1 : r_c_tz[5:0];
    assign x_adj   = eq ? {r_c_data[63:1], 1'b0} : r_c_data;
    assign reuse   = r_wv[r_c_idx] && (lzc >= r_wl_rd) && (tz_adj >= r_wt_rd);
    assign shamt   = reuse ? r_wt_rd : tz_adj;
    assign sig     = 7'd64 - {2'd0, (reuse ? r_wl_rd : lzc)} - {1'd0, shamt};
    assign payload = x_adj >> shamt;
    assign low     = r_c_data[31:0];

    always_comb begin
        f_bits = TRAILER;
        f_len  = 7'd37;
        case (r_c_op)
            gmc_pkg::OP_HEADER, gmc_pkg::OP_FIRST_VALUE: begin
                f_bits = r_c_data;
                f_len  = 7'd64;
            end
            gmc_pkg::OP_FIRST_TIME: begin
                f_bits = r_c_data & ~(64'hFFFF_FFFF_FFFF_FFFF << i_fdw);
                f_len  = {1'b0, i_fdw};
            end
            gmc_pkg::OP_TIME: begin
                if (r_c_zero) begin
                    f_bits = '0;
                    f_len  = 7'd1;
                end else if (low == '0 || low[31:12] != '0) begin
                    f_bits = PFX_32 | {32'd0, low};
                    f_len  = 7'd36;
                end else if (low[31:7] == '0) begin
                    f_bits = PFX_7 | {57'd0, low[6:0]};
                    f_len  = 7'd9;
                end else if (low[31:9] == '0) begin
                    f_bits = PFX_9 | {55'd0, low[8:0]};
                    f_len  = 7'd12;
                end else begin
                    f_bits = PFX_12 | {52'd0, low[11:0]};
                    f_len  = 7'd16;
                end
            end
            gmc_pkg::OP_VALUE: begin
                if (r_c_zero) begin
                    f_bits = '0;
                    f_len  = 7'd1;
                end else if (reuse) begin
                    f_bits = CTRL_OLD;
                    f_len  = 7'd2;
                end else begin
                    f_bits = CTRL_NEW | {53'd0, lzc, sig[5:0]};
                    f_len  = 7'd13;
                end
            end
            default: begin
                f_bits = TRAILER;
                f_len  = 7'd37;
            end
        endcase
    end

    assign o_free = !r_o_valid || i_ready;
    assign two    = (r_c_op == gmc_pkg::OP_VALUE) && !r_c_zero;
    assign c_emit = r_c_valid && o_free;
    assign c_done = c_emit && (!two || r_c_second);
    assign c_take = !r_c_valid || c_done;

    always_ff @(posedge i_clk) begin
        if (c_emit && !r_c_second && two) begin
            r_pay     <= payload;
            r_pay_len <= sig;
        end
        if (c_emit) begin
            r_o_bits <= r_c_second ? r_pay : f_bits;
            r_o_len  <= r_c_second ? r_pay_len : f_len;
            r_o_last <= r_c_second || !two;
        end
        if (c_emit && !r_c_second && two && !reuse) begin
            r_wl_mem[r_c_idx] <= lzc;
            r_wt_mem[r_c_idx] <= tz_adj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_c_second   <= 1'b0;
            r_o_valid    <= 1'b0;
            r_prev_delta <= '0;
            r_wv         <= '0;
        end else begin
            if (o_q_pop) begin
                r_e_valid <= 1'b1;
            end else if (e_move) begin
                r_e_valid <= 1'b0;
            end
            if (e_move) begin
                r_c_valid <= 1'b1;
            end else if (c_done) begin
                r_c_valid <= 1'b0;
            end
            if (e_move && (r_e.op == gmc_pkg::OP_TIME || r_e.op == gmc_pkg::OP_FIRST_TIME)) begin
                r_prev_delta <= r_e.data;
            end
            if (c_done) begin
                r_c_second <= 1'b0;
            end else if (c_emit && two) begin
                r_c_second <= 1'b1;
            end
            if (c_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            // A window that is not valid reads as leading 0, trailing 64.
            if (c_emit && !r_c_second) begin
                if (r_c_op == gmc_pkg::OP_HEADER) begin
                    r_wv <= '0;
                end else if (r_c_op == gmc_pkg::OP_FIRST_VALUE) begin
                    r_wv[r_c_idx] <= 1'b0;
                end else if (two && !reuse) begin
                    r_wv[r_c_idx] <= 1'b1;
                end
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_bits  = r_o_bits;
    assign o_len   = r_o_len;
    assign o_last  = r_o_last;

    a_second_is_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_second |-> (r_c_valid && r_c_op == gmc_pkg::OP_VALUE && !r_c_zero))
        else $error("payload phase without a changed value");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_second |-> (r_pay_len != '0 && r_pay_len < 7'd64))
        else $error("payload length out of range");

    a_payload_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_emit && r_c_second) |=> (r_o_valid && r_o_last))
        else $error("payload chunk not marked last");

    a_window_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_emit && !r_c_second && two && !reuse) |-> ({2'd0, lzc} + {1'd0, tz_adj} <= 7'd64))
        else $error("new window wider than the word");

endmodule

// ===== hdl/gorilla_multi_column_compressor_top.sv =====
// Top level of the multi-column time-series compressor with stream ports.
// Path: an accepted item is written into the queue, then passes the evaluate stage,
// the chunk stage and the output register, where its first chunk becomes valid.
// Throughput: one item per cycle for items that give one chunk while the output is
// ready; a changed column value gives a control and a payload chunk, so it holds the
// chunk stage for both. The output register has a single chunk port, which sets the rate.
// Reset: synchronous, active low; clears timing state, queue, stages and the window
// valid bits at once, so items are accepted as soon as reset is released.
module gorilla_multi_column_compressor_top #(
    parameter int MAX_COLUMNS = gmc_pkg::MAX_COLUMNS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input items.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: timestamp[63:0], value_bits[127:64], column[131:128],
    // zero fill [135:132].
    input  logic [135:0] s_axis_tdata,
    // tuser from bit 0: req_type[1:0].
    input  logic [1:0]   s_axis_tuser,
    // Result items.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: chunk_bits[63:0], chunk_length[70:64], zero fill [71].
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    // Configuration writes.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gmc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                        q_push;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_empty;
    gmc_pkg::t_op                q_item;
    gmc_pkg::t_op                q_head;
    logic [gmc_pkg::FDW_W-1:0]   fdw;
    logic [gmc_pkg::CHUNK_W-1:0] out_bits;
    logic [gmc_pkg::LEN_W-1:0]   out_len;

    // The front end keeps the row timing state, drops values that cannot be
    // coded (column out of range, or no row opened yet) and turns each item
    // into one encoding operation.
    gmc_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_timestamp  (s_axis_tdata[63:0]),
        .i_value_bits (s_axis_tdata[127:64]),
        .i_column     (s_axis_tdata[131:128]),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_item     (q_item),
        .o_fdw        (fdw)
    );

    // The queue lets the front end keep accepting while the encoder is busy with
    // a payload chunk or the output side stalls.
    gmc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The encoder owns the previous values, the delta-of-delta history and the
    // per-column windows, and forms the chunks in stream order.
    gmc_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_fdw     (fdw),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_bits    (out_bits),
        .o_len     (out_len),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_len, out_bits};

endmodule

// ===== sim/gmc_chunk_checker.sv =====
// Chunk stream checker for the multi-column time-series compressor.
module gmc_chunk_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [135:0]                   i_s_tdata,
    input  logic [1:0]                     i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [71:0]                    i_m_tdata,
    input  logic                           i_m_tlast,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [gmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    // Trailer of a closed block: 1111, thirty-two ones, 0.
    localparam logic [63:0] TRAILER = {27'd0, 4'hF, 32'hFFFF_FFFF, 1'b0};

    typedef struct packed {
        logic [gmc_pkg::CHUNK_W-1:0] bits;
        logic [gmc_pkg::LEN_W-1:0]   len;
        logic                        last;
    } t_chunk;

    t_chunk                     chunk_q[$];
    logic [gmc_pkg::NCOL_W-1:0] ncol_reg;
    logic [gmc_pkg::FDW_W-1:0]  fdw_reg;
    logic [63:0]                blk_start;
    logic [63:0]                last_time;
    logic [63:0]                last_delta;
    logic                       row_pending;
    logic                       first_row;
    logic [63:0]                col_value [gmc_pkg::MAX_COLUMNS_DEF];
    int unsigned                win_lead  [gmc_pkg::MAX_COLUMNS_DEF];
    int unsigned                win_trail [gmc_pkg::MAX_COLUMNS_DEF];
    int                         fail_cnt;

    function automatic void push_chunk(input logic [63:0] bits, input int unsigned len,
                                       input logic last);
        t_chunk c;
        c.bits  = (len >= 64) ? bits : bits & ((64'd1 << len) - 64'd1);
        c.len   = gmc_pkg::LEN_W'(len);
        c.last  = last;
        chunk_q = {chunk_q, c};
    endfunction

    function automatic void code_timestamp(input logic [63:0] t);
        logic [63:0] nd, dod, zz;
        logic [31:0] low;
        int unsigned w, blen, i;
        if (row_pending) begin
            w = fdw_reg;
            if (w < 1) w = 1;
            if (w > 32) w = 32;
            last_delta  = t - blk_start;
            last_time   = t;
            row_pending = 1'b0;
            first_row   = 1'b1;
            push_chunk(last_delta, w, 1'b1);
            return;
        end
        first_row  = 1'b0;
        nd         = t - last_time;
        dod        = nd - last_delta;
        last_delta = nd;
        last_time  = t;
        if (dod == 64'd0) begin
            push_chunk(64'd0, 1, 1'b1);
            return;
        end
        // Zigzag code; only its low half is ever sent.
        zz   = (dod << 1) ^ {64{dod[63]}};
        low  = zz[31:0];
        blen = 0;
        for (i = 0; i < 32; i++) if (low[i]) blen = i + 1;
        if (blen >= 1 && blen <= 7)        push_chunk(64'(low[6:0]) | 64'h100, 9, 1'b1);
        else if (blen >= 8 && blen <= 9)   push_chunk(64'(low[8:0]) | 64'hC00, 12, 1'b1);
        else if (blen >= 10 && blen <= 12) push_chunk(64'(low[11:0]) | 64'hE000, 16, 1'b1);
        else                               push_chunk({28'd0, 4'hF, low}, 36, 1'b1);
    endfunction

    function automatic void code_value(input logic [63:0] v, input int unsigned col);
        int unsigned ncol, lz, tz, sig, sl, st;
        logic [63:0] x;
        ncol = ncol_reg;
        if (ncol < 1) ncol = 1;
        if (ncol > gmc_pkg::MAX_COLUMNS_DEF) ncol = gmc_pkg::MAX_COLUMNS_DEF;
        if (col >= ncol || row_pending) return;
        if (first_row) begin
            col_value[col] = v;
            win_lead[col]  = 0;
            win_trail[col] = 64;
            push_chunk(v, 64, 1'b1);
            return;
        end
        x              = col_value[col] ^ v;
        col_value[col] = v;
        if (x == 64'd0) begin
            push_chunk(64'd0, 1, 1'b1);
            return;
        end
        lz = 0;
        while (!x[63 - lz]) lz++;
        tz = 0;
        while (!x[tz]) tz++;
        if (lz > 31) lz = 31;
        // Equal counts: drop the lowest bit and claim one trailing zero.
        if (lz == tz) begin
            x[0] = 1'b0;
            tz   = 1;
        end
        if (lz >= win_lead[col] && tz >= win_trail[col] && win_trail[col] < 64) begin
            sl  = win_lead[col];
            st  = win_trail[col];
            sig = (sl + st <= 64) ? 64 - sl - st : 0;
            push_chunk(64'd2, 2, 1'b0);
            push_chunk(x >> st, sig, 1'b1);
            return;
        end
        sig = 64 - lz - tz;
        push_chunk((64'd3 << 11) | (64'(lz) << 6) | 64'(sig & 63), 13, 1'b0);
        push_chunk(x >> (tz & 63), sig, 1'b1);
        win_lead[col]  = lz;
        win_trail[col] = tz;
    endfunction

    always @(posedge i_clk) begin : watch
        t_chunk got, want;
        int c;
        if (!i_rst_n) begin
            ncol_reg    = 5'd1;
            fdw_reg     = 6'd14;
            blk_start   = '0;
            last_time   = '0;
            last_delta  = '0;
            row_pending = 1'b1;
            first_row   = 1'b0;
            fail_cnt    = 0;
            for (c = 0; c < gmc_pkg::MAX_COLUMNS_DEF; c++) begin
                col_value[c] = '0;
                win_lead[c]  = 0;
                win_trail[c] = 64;
            end
            chunk_q.delete();
        end else begin
            // Results are compared before this edge's input is predicted; no item
            // can reach the output in the cycle it is accepted.
            if (i_m_tvalid && i_m_tready) begin
                got.bits = i_m_tdata[63:0];
                got.len  = i_m_tdata[70:64];
                got.last = i_m_tlast;
                if (chunk_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: unexpected chunk bits %h len %0d last %b",
                                 $realtime, got.bits, got.len, got.last);
                end else begin
                    want = chunk_q.pop_front();
                    if (got.bits !== want.bits || got.len !== want.len ||
                        got.last !== want.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"%0t: chunk mismatch, expected bits %h len %0d last %b,",
                                      " got bits %h len %0d last %b"}, $realtime,
                                     want.bits, want.len, want.last,
                                     got.bits, got.len, got.last);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    gmc_pkg::CFG_NUM_COLUMNS:
                        ncol_reg = i_cfg_data[gmc_pkg::NCOL_W-1:0];
                    gmc_pkg::CFG_FIRST_DELTA_WIDTH:
                        fdw_reg = i_cfg_data[gmc_pkg::FDW_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    gmc_pkg::REQ_OPEN: begin
                        blk_start   = i_s_tdata[63:0];
                        last_time   = '0;
                        last_delta  = '0;
                        row_pending = 1'b1;
                        first_row   = 1'b0;
                        for (c = 0; c < gmc_pkg::MAX_COLUMNS_DEF; c++) begin
                            win_lead[c]  = 0;
                            win_trail[c] = 64;
                        end
                        push_chunk(i_s_tdata[63:0], 64, 1'b1);
                    end
                    gmc_pkg::REQ_ROW:   code_timestamp(i_s_tdata[63:0]);
                    gmc_pkg::REQ_VALUE: code_value(i_s_tdata[127:64], i_s_tdata[131:128]);
                    default:            push_chunk(TRAILER, 37, 1'b1);
                endcase
            end
        end
        o_pending    <= chunk_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ===== sim/tb_gorilla_multi_column_compressor_top.sv =====
// Testbench top for the multi-column time-series compressor: stimulus and verdict.
module tb_gorilla_multi_column_compressor_top;

    // Where the stimulus stands inside the current block. It only steers which
    // items are legal to send; the checker keeps its own full prediction.
    typedef enum logic [1:0] {
        ROW_NONE,
        ROW_FIRST,
        ROW_LATER
    } t_row_phase;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [135:0]                   s_axis_tdata = '0;
    logic [1:0]                     s_axis_tuser = gmc_pkg::REQ_OPEN;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [71:0]                    m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gmc_pkg::CFG_IDX_W-1:0]  cfg_index = gmc_pkg::CFG_NUM_COLUMNS;
    logic [gmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int                             mismatch_total;
    int                             chunks_outstanding;

    // Stimulus-side view of the block, used to build well-formed rows.
    int unsigned                    ncol_active = 1;
    t_row_phase                     row_phase = ROW_NONE;
    logic [63:0]                    open_time = '0;
    logic [63:0]                    row_time = '0;
    logic [63:0]                    row_delta = '0;
    logic [63:0]                    col_prev [gmc_pkg::MAX_COLUMNS_DEF];
    logic [15:0]                    col_loaded = '0;
    int unsigned                    counted_items = 0;
    bit                             src_idle = 1'b0;
    bit                             sink_idle = 1'b0;

    gorilla_multi_column_compressor_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // The checker watches all three channels and keeps the expected chunks.
    gmc_chunk_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (mismatch_total),
        .o_pending    (chunks_outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side: while stalling is enabled, ready drops at random points, so stalls
    // land on control and payload chunks alike.
    initial begin : sink
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                hold--;
                m_axis_tready <= (hold == 0);
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Delta-of-delta for the next row, spread over every prefix class, including
    // nonzero codes whose low half is zero.
    function automatic logic [63:0] pick_dod();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1:    return 64'd0;
            2, 3:    return 64'($urandom_range(0, 126)) - 64'd63;
            4:       return 64'($urandom_range(0, 510)) - 64'd255;
            5:       return 64'($urandom_range(0, 4094)) - 64'd2047;
            6:       return {{32{r[31]}}, r};
            7:       return rand64();
            8:       return {1'b0, r, 31'd0};
            default: return 64'($urandom_range(0, 20));
        endcase
    endfunction

    // XOR against the previous value of a column: equal, narrow windows that may
    // fit the stored one, single bits, equal leading and trailing counts, and
    // patterns whose leading count exceeds the cap.
    function automatic logic [63:0] pick_xor();
        int unsigned lo, hi, k;
        logic [63:0] mask;
        case ($urandom_range(0, 9))
            0, 1: return 64'd0;
            2:    return rand64();
            3, 4: begin
                lo   = $urandom_range(0, 62);
                hi   = $urandom_range(lo, 63);
                mask = ((hi == 63) ? '1 : (64'd1 << (hi + 1)) - 64'd1) &
                       ~((64'd1 << lo) - 64'd1);
                return (rand64() & mask) | (64'd1 << lo);
            end
            5:    return 64'd1 << $urandom_range(0, 63);
            6: begin
                k = $urandom_range(0, 31);
                return (64'd1 << (63 - k)) | (64'd1 << k);
            end
            7:    return 64'd1 << 31;
            8:    return 64'($urandom_range(1, 255));
            default: return (rand64() & 64'h0000_01FF_FFF0_0000) | (64'd1 << 30);
        endcase
    endfunction

    function automatic logic [63:0] pick_edge_or_rand();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    // Presents one item and returns at the edge where it is taken. An idle gap,
    // when drawn, comes before the item so valid is never lowered and raised in
    // the same step.
    task automatic put_item(input logic [1:0] kind, input logic [63:0] ts,
                            input logic [63:0] val, input logic [3:0] col);
        int unsigned gap;
        if (src_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'd0, col, val, ts};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic open_block(input logic [63:0] ts);
        put_item(gmc_pkg::REQ_OPEN, ts, rand64(), 4'($urandom));
        open_time = ts;
        row_time  = '0;
        row_delta = '0;
        row_phase = ROW_NONE;
        counted_items++;
    endtask

    task automatic close_block();
        put_item(gmc_pkg::REQ_CLOSE, rand64(), rand64(), 4'($urandom));
        counted_items++;
    endtask

    task automatic row_item(input logic [63:0] ts);
        put_item(gmc_pkg::REQ_ROW, ts, rand64(), 4'($urandom));
        if (row_phase == ROW_NONE) begin
            row_delta = ts - open_time;
            row_phase = ROW_FIRST;
        end else begin
            row_delta = ts - row_time;
            row_phase = ROW_LATER;
        end
        row_time = ts;
        counted_items++;
    endtask

    // The first row of a block gets a delta of random size, which may overflow
    // the configured width; later rows follow the requested delta-of-delta.
    task automatic row_by_dod(input logic [63:0] dod);
        if (row_phase == ROW_NONE)
            row_item(open_time + (rand64() >> $urandom_range(0, 63)));
        else
            row_item(row_time + row_delta + dod);
    endtask

    // A later-row value for a column that never had a first value is not sent:
    // its previous value would be unwritten storage.
    task automatic value_item(input int unsigned col, input logic [63:0] v);
        logic in_range;
        in_range = (col < ncol_active);
        if (in_range && row_phase == ROW_LATER && !col_loaded[col]) return;
        put_item(gmc_pkg::REQ_VALUE, rand64(), v, 4'(col));
        if (in_range && row_phase != ROW_NONE) begin
            counted_items++;
            col_prev[col] = v;
            if (row_phase == ROW_FIRST) col_loaded[col] = 1'b1;
        end
    endtask

    // Noise between values: ignored columns, stray closes, rows that cut a row
    // short, and repeated values for a column.
    task automatic inject_noise();
        case ($urandom_range(0, 3))
            0: begin
                if (ncol_active < 16)
                    value_item($urandom_range(ncol_active, 15), rand64());
            end
            1: close_block();
            2: row_by_dod(pick_dod());
            default: value_item(0, col_prev[0] ^ pick_xor());
        endcase
    endtask

    task automatic run_block(input int unsigned rows, input bit quiet);
        int unsigned r, c;
        src_idle  = !quiet && ($urandom_range(0, 3) != 0);
        sink_idle = !quiet && ($urandom_range(0, 3) != 0);
        open_block(pick_edge_or_rand());
        if ($urandom_range(0, 9) == 0) value_item(0, rand64());
        for (r = 0; r < rows; r++) begin
            row_by_dod(pick_dod());
            for (c = 0; c < ncol_active; c++) begin
                if ($urandom_range(0, 11) == 0) inject_noise();
                // A skipped column leaves a broken row behind.
                if ($urandom_range(0, 40) == 0) continue;
                if (row_phase == ROW_FIRST)
                    value_item(c, pick_edge_or_rand());
                else
                    value_item(c, col_prev[c] ^ pick_xor());
            end
        end
        if ($urandom_range(0, 4) != 0) close_block();
    endtask

    // Waits until every expected chunk has come back, then lets the pipeline
    // settle, since ignored items give no chunk to wait for.
    task automatic wait_idle(input int unsigned settle);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chunks_outstanding != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes both registers back to back; valid stays high between the two.
    task automatic write_regs(input logic [5:0] ncol_val, input logic [5:0] fdw_val);
        int unsigned n;
        cfg_valid <= 1'b1;
        cfg_index <= gmc_pkg::CFG_NUM_COLUMNS;
        cfg_data  <= ncol_val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_index <= gmc_pkg::CFG_FIRST_DELTA_WIDTH;
        cfg_data  <= fdw_val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        n = ncol_val[4:0];
        if (n < 1) n = 1;
        if (n > gmc_pkg::MAX_COLUMNS_DEF) n = gmc_pkg::MAX_COLUMNS_DEF;
        ncol_active = n;
    endtask

    initial begin : stimulus
        logic [5:0] ncol_cfg [8];
        logic [5:0] fdw_cfg [8];
        int unsigned p, goal;

        // Register settings per random phase: both extremes, zero and oversized
        // values that the block clamps, and two random pairs. The last phase
        // runs without any idling.
        ncol_cfg[0] = 6'd16; fdw_cfg[0] = 6'd32;
        ncol_cfg[1] = 6'd0;  fdw_cfg[1] = 6'd1;
        ncol_cfg[2] = 6'd31; fdw_cfg[2] = 6'd0;
        ncol_cfg[3] = 6'd40; fdw_cfg[3] = 6'd63;
        ncol_cfg[4] = 6'd5;  fdw_cfg[4] = 6'd33;
        ncol_cfg[5] = 6'($urandom_range(0, 63)); fdw_cfg[5] = 6'($urandom_range(0, 63));
        ncol_cfg[6] = 6'($urandom_range(0, 63)); fdw_cfg[6] = 6'($urandom_range(0, 63));
        ncol_cfg[7] = 6'd16; fdw_cfg[7] = 6'd20;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with reset settings: one column, 14-bit first delta.
        // A value before any row and right after an open is ignored.
        value_item(0, rand64());
        open_block('1);
        value_item(0, rand64());
        row_item(64'h0000_0000_0000_3FFF);
        value_item(0, '1);
        // Column out of range is ignored.
        value_item(15, 64'd0);
        // Each row walks one prefix class and each value one coding case.
        row_by_dod(64'd0);
        value_item(0, col_prev[0]);
        row_by_dod(64'd5);
        // Leading count above the cap that then equals the trailing count.
        value_item(0, col_prev[0] ^ (64'd1 << 31));
        row_by_dod(64'd0 - 64'd200);
        // Equal leading and trailing counts.
        value_item(0, col_prev[0] ^ ((64'd1 << 58) | (64'd1 << 5)));
        row_by_dod(64'd2000);
        // Fits the stored window, so the window is reused.
        value_item(0, col_prev[0] ^ ((64'd1 << 30) | (64'd1 << 20)));
        // Nonzero code with a zero low half.
        row_by_dod(64'h0000_0000_8000_0000);
        value_item(0, col_prev[0] ^ 64'd1);
        row_by_dod(64'hFFFF_FFFF_8000_0000);
        value_item(0, ~col_prev[0]);
        row_by_dod(64'h7FFF_FFFF_FFFF_FFFF);
        value_item(0, col_prev[0]);
        close_block();
        open_block(64'd0);
        row_item(64'd0);
        value_item(0, 64'd0);
        close_block();

        // Random part: blocks of well-formed rows with noise mixed in, one
        // register setting per phase.
        for (p = 0; p < 8; p++) begin
            wait_idle(8);
            write_regs(ncol_cfg[p], fdw_cfg[p]);
            goal = counted_items + 190;
            while (counted_items < goal) run_block($urandom_range(1, 6), p == 7);
        end

        wait_idle(20);
        if (mismatch_total == 0 && chunks_outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
